FILE: src/recency_ordered_id_list_macros.svh
// Assertion macros shared by the checker of the recency ordered id list.
// Depends on nothing; every macro expects a clock named clk and reset rst_n.
`ifndef RECENCY_ORDERED_ID_LIST_MACROS_SVH
`define RECENCY_ORDERED_ID_LIST_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ROL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ROL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/rol_pkg.sv
// Types, command codes and sizing constants for the recency ordered id list.
// Depends on nothing; used by every module of the block.
package rol_pkg;

  localparam int DEPTH_DEF = 64;

  localparam logic [2:0] CMD_CLEAR = 3'd0;
  localparam logic [2:0] CMD_LOAD  = 3'd1;
  localparam logic [2:0] CMD_MTF   = 3'd2;
  localparam logic [2:0] CMD_REM   = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [30:0]        user_id;
    logic signed [31:0] online_time;
    logic [6:0]         begin_index;
    logic signed [7:0]  limit;
  } in_req_t;

  typedef struct packed {
    logic [30:0] out_id;
    logic        is_last;
    logic        empty_slice;
    logic [6:0]  entry_count;
    logic        load_dropped;
  } out_res_t;

  typedef struct packed {
    logic [30:0]        id;
    logic signed [31:0] otime;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_SHDN,
    ST_SHUP,
    ST_PUT,
    ST_RD,
    ST_EMIT
  } st_t;

endpackage

FILE: src/rol_mem.sv
// List storage: one write port, one read port with registered read data.
// Depends on rol_pkg for the entry type.
module rol_mem #(
  parameter int DEPTH = rol_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  rol_pkg::entry_t          wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output rol_pkg::entry_t          rd_data
);
  import rol_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/recency_ordered_id_list.sv
// Recency ordered id list: a time ordered list with move-to-front, kept in one memory.
// Clear, unknown commands, dropped loads and empty reads give one result without an id; load,
// move and remove scan for the position, then shift one entry per cycle.
// A read range gives one id per cycle from its first id on; busy
// is low again in the cycle of the last result. The receiver cannot stall. Synchronous
// active-low reset empties the list; memory contents are never cleared.
module recency_ordered_id_list #(
  parameter int DEPTH = rol_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rol_pkg::in_req_t  in_req,
  output logic              out_valid,
  output rol_pkg::out_res_t out_res
);
  import rol_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = ((CW > 8) ? CW : 8) + 1;

  st_t state_r, state_nxt;

  logic [2:0]         cmd_r, cmd_nxt;
  logic [30:0]        id_r, id_nxt;
  logic signed [31:0] t_r, t_nxt;
  logic signed [31:0] newt_r, newt_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      ptr_r, ptr_nxt;
  logic [CW-1:0]      rem_r, rem_nxt;
  logic [CW-1:0]      pidx_r, pidx_nxt;
  logic [CW-1:0]      lo_r, lo_nxt;
  logic               pend_r, pend_nxt;
  logic               plast_r, plast_nxt;
  logic               drop_r, drop_nxt;
  logic               outv_r, outv_nxt;
  out_res_t           res_r, res_nxt;

  logic               wr_en, rd_en;
  logic [AW-1:0]      wr_addr, rd_addr;
  entry_t             wr_data, rd_data;

  rol_mem #(.DEPTH(DEPTH)) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Scan results: data read in the previous cycle is tested here.
  logic          hit, find_done, issue, full;
  logic [CW-1:0] pos;

  assign full      = (cnt_r == CW'(DEPTH));
  assign hit       = pend_r && ((cmd_r == CMD_LOAD) ? (rd_data.otime <= t_r)
                                                    : (rd_data.id == id_r));
  assign find_done = hit || (!pend_r && (ptr_r == cnt_r));
  assign pos       = hit ? pidx_r : cnt_r;

  always_comb begin
    issue = 1'b0;
    case (state_r)
      ST_FIND: issue = (ptr_r < cnt_r) && !find_done;
      ST_SHDN, ST_SHUP, ST_RD: issue = (rem_r != '0);
      default: issue = 1'b0;
    endcase
  end

  // Read range bounds for the request on the input port.
  logic          rd_empty;
  logic [CW-1:0] rd_start, rd_stop;
  logic [SW-1:0] rd_sum;

  always_comb begin
    rd_sum = SW'(in_req.begin_index) + SW'($unsigned(in_req.limit));
    if (in_req.limit[7]) begin
      rd_start = '0;
      rd_stop  = cnt_r;
      rd_empty = (cnt_r == '0);
    end else begin
      rd_start = CW'(in_req.begin_index);
      rd_stop  = (rd_sum >= SW'(cnt_r)) ? cnt_r : CW'(rd_sum);
      rd_empty = (SW'(in_req.begin_index) >= SW'(cnt_r)) || (in_req.limit == '0);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_req.cmd)
            CMD_LOAD: state_nxt = full ? ST_EMIT : ST_FIND;
            CMD_MTF, CMD_REM: state_nxt = ST_FIND;
            CMD_READ: state_nxt = rd_empty ? ST_EMIT : ST_RD;
            default: state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_FIND: begin
        if (find_done) begin
          case (cmd_r)
            CMD_LOAD: state_nxt = (pos < cnt_r) ? ST_SHDN : ST_PUT;
            CMD_MTF: begin
              if (!hit) begin
                state_nxt = ST_EMIT;
              end else begin
                state_nxt = (pos != '0) ? ST_SHDN : ST_PUT;
              end
            end
            CMD_REM: begin
              if (!hit) begin
                state_nxt = ST_EMIT;
              end else begin
                state_nxt = ((pos + 1'b1) < cnt_r) ? ST_SHUP : ST_EMIT;
              end
            end
            default: state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_SHDN: if (rem_r == '0 && !pend_r) state_nxt = ST_PUT;
      ST_SHUP: if (rem_r == '0 && !pend_r) state_nxt = ST_EMIT;
      ST_PUT:  state_nxt = ST_EMIT;
      ST_RD:   if (pend_r && plast_r) state_nxt = ST_IDLE;
      ST_EMIT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_nxt   = cmd_r;
    id_nxt    = id_r;
    t_nxt     = t_r;
    newt_nxt  = newt_r;
    cnt_nxt   = cnt_r;
    ptr_nxt   = ptr_r;
    rem_nxt   = rem_r;
    lo_nxt    = lo_r;
    drop_nxt  = drop_r;
    pend_nxt  = issue;
    pidx_nxt  = ptr_r;
    plast_nxt = (rem_r == CW'(1));
    outv_nxt  = 1'b0;
    res_nxt   = res_r;
    rd_en     = issue;
    rd_addr   = AW'(ptr_r);
    wr_en     = 1'b0;
    wr_addr   = AW'(lo_r);
    wr_data   = rd_data;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt  = in_req.cmd;
          id_nxt   = in_req.user_id;
          t_nxt    = in_req.online_time;
          drop_nxt = 1'b0;
          ptr_nxt  = '0;
          case (in_req.cmd)
            CMD_CLEAR: cnt_nxt = '0;
            CMD_LOAD: drop_nxt = full;
            CMD_READ: begin
              ptr_nxt = rd_start;
              rem_nxt = rd_stop - rd_start;
            end
            default: ;
          endcase
        end
      end
      ST_FIND: begin
        if (issue) begin
          ptr_nxt = ptr_r + 1'b1;
        end
        if (find_done) begin
          case (cmd_r)
            CMD_LOAD: begin
              lo_nxt   = pos;
              newt_nxt = t_r;
              rem_nxt  = cnt_r - pos;
              ptr_nxt  = cnt_r - 1'b1;
            end
            CMD_MTF: begin
              lo_nxt   = '0;
              newt_nxt = rd_data.otime;
              rem_nxt  = pos;
              ptr_nxt  = pos - 1'b1;
            end
            CMD_REM: begin
              rem_nxt = cnt_r - pos - 1'b1;
              ptr_nxt = pos + 1'b1;
              if (hit) cnt_nxt = cnt_r - 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_SHDN: begin
        // Entries move one place toward the tail, last one first.
        if (issue) begin
          ptr_nxt = ptr_r - 1'b1;
          rem_nxt = rem_r - 1'b1;
        end
        wr_en   = pend_r;
        wr_addr = AW'(pidx_r + 1'b1);
      end
      ST_SHUP: begin
        if (issue) begin
          ptr_nxt = ptr_r + 1'b1;
          rem_nxt = rem_r - 1'b1;
        end
        wr_en   = pend_r;
        wr_addr = AW'(pidx_r - 1'b1);
      end
      ST_PUT: begin
        wr_en   = 1'b1;
        wr_addr = AW'(lo_r);
        wr_data = '{id: id_r, otime: newt_r};
        if (cmd_r == CMD_LOAD) cnt_nxt = cnt_r + 1'b1;
      end
      ST_RD: begin
        if (issue) begin
          ptr_nxt = ptr_r + 1'b1;
          rem_nxt = rem_r - 1'b1;
        end
        if (pend_r) begin
          outv_nxt = 1'b1;
          res_nxt  = '{out_id: rd_data.id, is_last: plast_r, empty_slice: 1'b0,
                       entry_count: 7'(cnt_r), load_dropped: 1'b0};
        end
      end
      ST_EMIT: begin
        outv_nxt = 1'b1;
        res_nxt  = '{out_id: '0, is_last: 1'b1, empty_slice: 1'b1,
                     entry_count: 7'(cnt_r), load_dropped: drop_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      outv_r  <= outv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    id_r    <= id_nxt;
    t_r     <= t_nxt;
    newt_r  <= newt_nxt;
    ptr_r   <= ptr_nxt;
    rem_r   <= rem_nxt;
    pidx_r  <= pidx_nxt;
    lo_r    <= lo_nxt;
    plast_r <= plast_nxt;
    drop_r  <= drop_nxt;
    res_r   <= res_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = outv_r;
  assign out_res   = res_r;

endmodule

FILE: src/rol_checker.sv
// Port-level checker for the recency ordered id list, bound to the top level.
// Depends on rol_pkg and the macros header.
`include "recency_ordered_id_list_macros.svh"

module rol_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input rol_pkg::in_req_t  in_req,
  input logic              out_valid,
  input rol_pkg::out_res_t out_res
);
  import rol_pkg::*;

  // An accepted request makes the block busy in the cycle after it is taken.
  `ROL_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // A result without an id carries zero and ends its request.
  `ROL_ASSERT_IMPL(a_empty_zero, out_valid && out_res.empty_slice,
                   out_res.out_id == '0 && out_res.is_last)
  // A dropped load never comes with an id.
  `ROL_ASSERT_IMPL(a_drop_empty, out_valid && out_res.load_dropped, out_res.empty_slice)
  // The block is idle in the cycle in which its final result is shown.
  `ROL_ASSERT_IMPL(a_last_idle, out_valid && out_res.is_last, !busy)

endmodule

bind recency_ordered_id_list rol_checker u_rol_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_req   (in_req),
  .out_valid(out_valid),
  .out_res  (out_res)
);
